/* sv/text_graphic_cell_renderer_core_assert.svh */
// Assertion macros for the cell renderer; empty when SYNTH is defined.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef TEXT_GRAPHIC_CELL_RENDERER_CORE_ASSERT_SVH
`define TEXT_GRAPHIC_CELL_RENDERER_CORE_ASSERT_SVH
`ifndef SYNTH
`define TGCR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgcr check failed");
`define TGCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgcr check failed");
`else
`define TGCR_ASSERT_SAME(lbl, ante, cons)
`define TGCR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/tgcr_pkg.sv */
`default_nettype none
package tgcr_pkg;

    // store geometry
    localparam int STORE_AW = 14;
    localparam int FONT_AW  = 11;
    localparam int SCAN_AW  = 11;
    localparam int PADDR_W  = 5;

    // input function codes
    localparam logic [2:0] FUNC_WR_CHAR  = 3'd0;
    localparam logic [2:0] FUNC_WR_FLAG  = 3'd1;
    localparam logic [2:0] FUNC_WR_FONT  = 3'd2;
    localparam logic [2:0] FUNC_TICK     = 3'd3;
    localparam logic [2:0] FUNC_START    = 3'd4;
    localparam logic [2:0] FUNC_RENDER   = 3'd5;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DISPLAY_MODE    = 3'd0;
    localparam logic [2:0] REG_CHARS_PER_ROW   = 3'd1;
    localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd2;
    localparam logic [2:0] REG_CURSOR_CONTROL  = 3'd3;
    localparam logic [2:0] REG_START_ADDRESS   = 3'd4;
    localparam logic [2:0] REG_CURSOR_ADDRESS  = 3'd5;

    // blink modes, cursor_control bits 6:5
    localparam logic [1:0] BLINK_STEADY = 2'b00;
    localparam logic [1:0] BLINK_NEVER  = 2'b01;
    localparam logic [1:0] BLINK_SLOW   = 2'b10;
    localparam logic [1:0] BLINK_FAST   = 2'b11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLOUR_RD,
        ST_COLOUR_DATA,
        ST_FLAG,
        ST_FLAG_END,
        ST_LINE_RD,
        ST_LINE_CALC,
        ST_LINE_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  display_mode;
        logic [7:0]  chars_per_row;
        logic [7:0]  display_control;
        logic [6:0]  cursor_control;
        logic [10:0] start_address;
        logic [10:0] cursor_address;
    } cfg_t;

    typedef struct packed {
        logic                char_we;
        logic                flag_we;
        logic                font_we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } st_wr_t;

    typedef struct packed {
        logic [STORE_AW-1:0] char_addr;
        logic [STORE_AW-1:0] flag_addr;
        logic [FONT_AW-1:0]  font_addr;
    } st_rd_t;

endpackage
`default_nettype wire

/* sv/tgcr_cfg.sv */
`default_nettype none
module tgcr_cfg
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [tgcr_pkg::PADDR_W-1:0]   paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tgcr_pkg::cfg_t                cfg
);

    tgcr_pkg::cfg_t cfg_reg;
    tgcr_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                tgcr_pkg::REG_DISPLAY_MODE:    cfg_next.display_mode    = pwdata[7:0];
                tgcr_pkg::REG_CHARS_PER_ROW:   cfg_next.chars_per_row   = pwdata[7:0];
                tgcr_pkg::REG_DISPLAY_CONTROL: cfg_next.display_control = pwdata[7:0];
                tgcr_pkg::REG_CURSOR_CONTROL:  cfg_next.cursor_control  = pwdata[6:0];
                tgcr_pkg::REG_START_ADDRESS:   cfg_next.start_address   = pwdata[10:0];
                tgcr_pkg::REG_CURSOR_ADDRESS:  cfg_next.cursor_address  = pwdata[10:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_mode    <= 8'd0;
            cfg_reg.chars_per_row   <= 8'd81;
            cfg_reg.display_control <= 8'd0;
            cfg_reg.cursor_control  <= 7'd0;
            cfg_reg.start_address   <= 11'd0;
            cfg_reg.cursor_address  <= 11'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            tgcr_pkg::REG_DISPLAY_MODE:    prdata = {24'd0, cfg_reg.display_mode};
            tgcr_pkg::REG_CHARS_PER_ROW:   prdata = {24'd0, cfg_reg.chars_per_row};
            tgcr_pkg::REG_DISPLAY_CONTROL: prdata = {24'd0, cfg_reg.display_control};
            tgcr_pkg::REG_CURSOR_CONTROL:  prdata = {25'd0, cfg_reg.cursor_control};
            tgcr_pkg::REG_START_ADDRESS:   prdata = {21'd0, cfg_reg.start_address};
            tgcr_pkg::REG_CURSOR_ADDRESS:  prdata = {21'd0, cfg_reg.cursor_address};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/tgcr_store.sv */
`default_nettype none
module tgcr_store
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  tgcr_pkg::st_wr_t                   wr,
    input  tgcr_pkg::st_rd_t                   rd,
    output logic [7:0]                         char_rdata,
    output logic                               flag_rdata,
    output logic [7:0]                         font_rdata,
    output logic                               busy
);

    localparam int CHAR_DEPTH = 1 << tgcr_pkg::STORE_AW;
    localparam int FONT_DEPTH = 1 << tgcr_pkg::FONT_AW;

    logic [7:0] char_mem [CHAR_DEPTH];
    logic       flag_mem [CHAR_DEPTH];
    logic [7:0] font_mem [FONT_DEPTH];

    logic [tgcr_pkg::STORE_AW-1:0] clr_cnt_reg;
    logic [tgcr_pkg::STORE_AW-1:0] clr_cnt_next;
    logic                          clr_busy_reg;
    logic                          clr_busy_next;
    logic [7:0]                    char_rdata_reg;
    logic                          flag_rdata_reg;
    logic [7:0]                    font_rdata_reg;

    logic                          char_we;
    logic                          flag_we;
    logic                          font_we;
    logic [tgcr_pkg::STORE_AW-1:0] waddr;
    logic [7:0]                    wdata;

    assign busy       = clr_busy_reg;
    assign char_rdata = char_rdata_reg;
    assign flag_rdata = flag_rdata_reg;
    assign font_rdata = font_rdata_reg;

    // clearing pass after reset takes the write port
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            char_we = 1'b1;
            flag_we = 1'b1;
            font_we = 1'b1;
            waddr   = clr_cnt_reg;
            wdata   = 8'd0;
        end
        else
        begin
            char_we = wr.char_we;
            flag_we = wr.flag_we;
            font_we = wr.font_we;
            waddr   = wr.addr;
            wdata   = wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[waddr] <= wdata;
        end
        char_rdata_reg <= char_mem[rd.char_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[waddr] <= |wdata;
        end
        flag_rdata_reg <= flag_mem[rd.flag_addr];
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[waddr[tgcr_pkg::FONT_AW-1:0]] <= wdata;
        end
        font_rdata_reg <= font_mem[rd.font_addr];
    end

endmodule
`default_nettype wire

/* sv/tgcr_line.sv */
`default_nettype none
module tgcr_line
(
    input  wire        scr_one,
    input  wire        scr_two,
    input  wire        graph,
    input  wire [7:0]  font_byte,
    input  wire [7:0]  char_byte,
    input  wire        flag_bit,
    input  wire [2:0]  row_colour,
    input  wire [2:0]  back,
    input  wire        cursor_on,
    input  wire        blank,
    output logic [23:0] pixels
);

    logic [7:0]  bits;
    logic [2:0]  cl;
    logic [2:0]  cr;
    logic [23:0] packed_line;

    // pick pattern and colours for this line
    always_comb
    begin
        bits = font_byte;
        cl   = row_colour;
        cr   = row_colour;
        if (graph && scr_one)
        begin
            if (flag_bit)
            begin
                cl   = char_byte[6:4];
                cr   = char_byte[2:0];
                bits = {{4{|char_byte[7:4]}}, {4{|char_byte[3:0]}}};
            end
            else
            begin
                bits = 8'd0;
            end
        end
        else if (graph && scr_two)
        begin
            bits = flag_bit ? char_byte : 8'd0;
            cl   = 3'd7;
            cr   = 3'd7;
        end
    end

    // leftmost pixel lands in the top bits
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (bits[7-i])
            begin
                packed_line[23-3*i -: 3] = (i < 4) ? cl : cr;
            end
            else
            begin
                packed_line[23-3*i -: 3] = back;
            end
        end
    end

    always_comb
    begin
        priority if (blank)
        begin
            pixels = 24'd0;
        end
        else if (cursor_on)
        begin
            pixels = 24'hffffff;
        end
        else
        begin
            pixels = packed_line;
        end
    end

endmodule
`default_nettype wire

/* sv/text_graphic_cell_renderer_core.sv */
`default_nettype none
// Cell renderer for a text/graphic display. Items arrive on the s_ stream; write, tick
// and start-frame items are taken in the idle state. A render item walks one cell with a
// sequencer around the stores: eight graphic flag reads, then for each of the eight lines
// a read step, a compose step through the shared line unit and an output beat, which can
// stall on m_tready; at the start of a row the colour byte is read first, and some render
// items give no beat. After reset the stores are swept to zero, during which no item is
// taken; the APB port works throughout.
`include "text_graphic_cell_renderer_core_assert.svh"
module text_graphic_cell_renderer_core
#(
    parameter int MAX_COLUMNS = 80
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [31:0]                    s_tdata,  // func[2:0] addr[16:3] data[24:17]
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [39:0]                   m_tdata,  // row[4:0] column[11:5] line[14:12] pixels[38:15]
    output logic                          m_tuser,  // wide
    output logic                          m_tlast,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [tgcr_pkg::PADDR_W-1:0]   paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    tgcr_pkg::cfg_t   cfg;
    tgcr_pkg::st_wr_t wr;
    tgcr_pkg::st_rd_t rd;
    tgcr_pkg::state_t state_reg;
    tgcr_pkg::state_t state_next;

    logic [7:0]  char_rdata;
    logic        flag_rdata;
    logic [7:0]  font_rdata;
    logic        store_busy;
    logic [23:0] line_pixels;

    logic [10:0] scan_reg, scan_next;
    logic [4:0]  row_reg, row_next;
    logic [6:0]  col_reg, col_next;
    logic [2:0]  colour_reg, colour_next;
    logic        frame_done_reg, frame_done_next;
    logic [4:0]  blink_reg, blink_next;
    logic [2:0]  kidx_reg, kidx_next;
    logic        pend_reg, pend_next;
    logic        graph_reg, graph_next;
    logic [7:0]  cell_char_reg, cell_char_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_pix_reg, out_pix_next;

    logic [2:0]  func;
    logic [13:0] in_addr;
    logic [7:0]  in_data;
    logic        accept;
    logic        scr_one;
    logic        scr_two;
    logic        scr_any;
    logic        wide;
    logic [4:0]  rows;
    logic [7:0]  cols;
    logic [7:0]  cpr_less;
    logic [13:0] gaddr;
    logic        cursor_hit;
    logic        blink_ok;
    logic        cursor_on;
    logic        blank;
    logic [7:0]  col_inc;
    logic [4:0]  row_inc;

    assign func    = s_tdata[2:0];
    assign in_addr = s_tdata[16:3];
    assign in_data = s_tdata[24:17];
    assign accept  = s_tvalid & s_tready;

    // mode decode
    assign scr_one = (cfg.display_mode[7:6] == 2'b01);
    assign scr_two = cfg.display_mode[7];
    assign scr_any = scr_one | scr_two;
    assign wide    = ~cfg.display_mode[5];
    assign rows    = cfg.display_mode[5] ? 5'd25 : 5'd24;

    // columns per row, clamped
    assign cpr_less = (cfg.chars_per_row == 8'd0) ? 8'd0 : cfg.chars_per_row - 8'd1;
    assign cols     = (cpr_less > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : cpr_less;

    // bank address for flag or graphic byte number kidx; mode 1 drops bit 11
    assign gaddr = {kidx_reg[2:1], (scr_one ? 1'b0 : kidx_reg[0]), scan_reg};

    // cursor and blanking
    always_comb
    begin
        unique case (cfg.cursor_control[6:5])
            tgcr_pkg::BLINK_STEADY: blink_ok = 1'b1;
            tgcr_pkg::BLINK_NEVER:  blink_ok = 1'b0;
            tgcr_pkg::BLINK_SLOW:   blink_ok = blink_reg[3];
            tgcr_pkg::BLINK_FAST:   blink_ok = blink_reg[4];
            default:                blink_ok = 1'b0;
        endcase
    end
    assign cursor_hit = (cfg.display_control[7:6] != 2'b11) &&
                        (scan_reg == cfg.cursor_address) && blink_ok;
    assign cursor_on  = cursor_hit && (kidx_reg >= cfg.cursor_control[2:0]);
    assign blank      = (cfg.display_control[5:4] == 2'b11);

    assign col_inc = {1'b0, col_reg} + 8'd1;
    assign row_inc = row_reg + 5'd1;

    tgcr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgcr_store u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd         (rd),
        .char_rdata (char_rdata),
        .flag_rdata (flag_rdata),
        .font_rdata (font_rdata),
        .busy       (store_busy)
    );

    tgcr_line u_line
    (
        .scr_one    (scr_one),
        .scr_two    (scr_two),
        .graph      (graph_reg),
        .font_byte  (font_rdata),
        .char_byte  (char_rdata),
        .flag_bit   (flag_rdata),
        .row_colour (colour_reg),
        .back       (cfg.display_mode[2:0]),
        .cursor_on  (cursor_on),
        .blank      (blank),
        .pixels     (line_pixels)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tgcr_pkg::ST_IDLE:
            begin
                if (accept && func == tgcr_pkg::FUNC_RENDER && !frame_done_reg)
                begin
                    state_next = (col_reg == 7'd0) ? tgcr_pkg::ST_COLOUR_RD :
                                 (cols == 8'd0)    ? tgcr_pkg::ST_IDLE
                                                   : tgcr_pkg::ST_FLAG;
                end
            end
            tgcr_pkg::ST_COLOUR_RD:   state_next = tgcr_pkg::ST_COLOUR_DATA;
            tgcr_pkg::ST_COLOUR_DATA:
            begin
                state_next = (cols == 8'd0) ? tgcr_pkg::ST_IDLE : tgcr_pkg::ST_FLAG;
            end
            tgcr_pkg::ST_FLAG:
            begin
                if (kidx_reg == 3'd7)
                begin
                    state_next = tgcr_pkg::ST_FLAG_END;
                end
            end
            tgcr_pkg::ST_FLAG_END:    state_next = tgcr_pkg::ST_LINE_RD;
            tgcr_pkg::ST_LINE_RD:     state_next = tgcr_pkg::ST_LINE_CALC;
            tgcr_pkg::ST_LINE_CALC:   state_next = tgcr_pkg::ST_LINE_OUT;
            tgcr_pkg::ST_LINE_OUT:
            begin
                if (m_tready)
                begin
                    state_next = (kidx_reg == 3'd7) ? tgcr_pkg::ST_IDLE
                                                    : tgcr_pkg::ST_LINE_RD;
                end
            end
            default:                  state_next = tgcr_pkg::ST_IDLE;
        endcase
    end

    // outputs: handshake, store access
    always_comb
    begin
        s_tready     = (state_reg == tgcr_pkg::ST_IDLE) && !store_busy;
        wr.char_we   = accept && (func == tgcr_pkg::FUNC_WR_CHAR);
        wr.flag_we   = accept && (func == tgcr_pkg::FUNC_WR_FLAG);
        wr.font_we   = accept && (func == tgcr_pkg::FUNC_WR_FONT);
        wr.addr      = in_addr;
        wr.data      = in_data;
        rd.char_addr = {3'd0, scan_reg};
        rd.flag_addr = gaddr;
        rd.font_addr = {cell_char_reg, kidx_reg};
        unique case (state_reg)
            tgcr_pkg::ST_LINE_RD: rd.char_addr = gaddr;
            default:              rd.char_addr = {3'd0, scan_reg};
        endcase
    end

    // datapath next values
    always_comb
    begin
        scan_next       = scan_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        colour_next     = colour_reg;
        frame_done_next = frame_done_reg;
        blink_next      = blink_reg;
        kidx_next       = kidx_reg;
        pend_next       = pend_reg;
        graph_next      = graph_reg;
        cell_char_next  = cell_char_reg;
        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        unique case (state_reg)
            tgcr_pkg::ST_IDLE:
            begin
                kidx_next  = 3'd0;
                pend_next  = 1'b0;
                graph_next = 1'b0;
                if (accept && func == tgcr_pkg::FUNC_TICK)
                begin
                    blink_next = blink_reg + 5'd1;
                end
                if (accept && func == tgcr_pkg::FUNC_START)
                begin
                    scan_next       = cfg.start_address;
                    row_next        = 5'd0;
                    col_next        = 7'd0;
                    frame_done_next = 1'b0;
                end
                if (accept && func == tgcr_pkg::FUNC_RENDER && !frame_done_reg &&
                    col_reg != 7'd0 && cols == 8'd0)
                begin
                    // row width dropped to nothing mid-row: end the row, no beat
                    col_next = 7'd0;
                    row_next = row_inc;
                    if (row_inc >= rows)
                    begin
                        frame_done_next = 1'b1;
                    end
                end
            end
            tgcr_pkg::ST_COLOUR_DATA:
            begin
                colour_next = char_rdata[2:0];
                scan_next   = scan_reg + 11'd1;
                if (cols == 8'd0)
                begin
                    // empty row: end it at once
                    col_next = 7'd0;
                    row_next = row_inc;
                    if (row_inc >= rows)
                    begin
                        frame_done_next = 1'b1;
                    end
                end
            end
            tgcr_pkg::ST_FLAG:
            begin
                pend_next = 1'b1;
                if (pend_reg && scr_any && flag_rdata)
                begin
                    graph_next = 1'b1;
                end
                kidx_next = kidx_reg + 3'd1;
            end
            tgcr_pkg::ST_FLAG_END:
            begin
                if (scr_any && flag_rdata)
                begin
                    graph_next = 1'b1;
                end
                cell_char_next = char_rdata;
                kidx_next      = 3'd0;
            end
            tgcr_pkg::ST_LINE_CALC:
            begin
                out_pix_next   = line_pixels;
                out_valid_next = 1'b1;
            end
            tgcr_pkg::ST_LINE_OUT:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    kidx_next      = kidx_reg + 3'd1;
                    if (kidx_reg == 3'd7)
                    begin
                        // cell done: step the walk
                        scan_next = scan_reg + 11'd1;
                        if (col_inc >= cols)
                        begin
                            col_next = 7'd0;
                            row_next = row_inc;
                            if (row_inc >= rows)
                            begin
                                frame_done_next = 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_inc[6:0];
                        end
                    end
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tgcr_pkg::ST_IDLE;
            scan_reg       <= 11'd0;
            row_reg        <= 5'd0;
            col_reg        <= 7'd0;
            colour_reg     <= 3'd0;
            frame_done_reg <= 1'b1;
            blink_reg      <= 5'd0;
            kidx_reg       <= 3'd0;
            pend_reg       <= 1'b0;
            graph_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            colour_reg     <= colour_next;
            frame_done_reg <= frame_done_next;
            blink_reg      <= blink_next;
            kidx_reg       <= kidx_next;
            pend_reg       <= pend_next;
            graph_reg      <= graph_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cell_char_reg <= cell_char_next;
        out_pix_reg   <= out_pix_next;
    end

    // result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pix_reg, kidx_reg, col_reg, row_reg};
    assign m_tuser  = wide;
    assign m_tlast  = (kidx_reg == 3'd7);

    `TGCR_ASSERT_SAME(a_no_take_while_beat, m_tvalid, !s_tready)
    `TGCR_ASSERT_SAME(a_beat_only_in_out, m_tvalid, state_reg == tgcr_pkg::ST_LINE_OUT)
    `TGCR_ASSERT_NEXT(a_last_ends_cell, m_tvalid && m_tready && m_tlast,
                      state_reg == tgcr_pkg::ST_IDLE)
    `TGCR_ASSERT_SAME(a_clear_blocks_input, store_busy, !s_tready)

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  column;
    logic [2:0]  line;
    logic [23:0] pixels;
    logic        wide;
    logic        last;
} cell_line_t;

// Expected cell lines are queued as render items are accepted, then matched in order
// against the output stream.
class cell_line_board;
    cell_line_t pending_lines[$];
    int errors;
    int beats_seen;

    function new();
        errors = 0;
        beats_seen = 0;
    endfunction

    function void note_line(cell_line_t ln);
        pending_lines.push_back(ln);
    endfunction

    function void check_beat(cell_line_t got);
        cell_line_t exp_ln;
        beats_seen++;
        if (pending_lines.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected beat %h", $realtime, got);
            return;
        end
        exp_ln = pending_lines.pop_front();
        if (exp_ln.row != got.row)
        begin
            errors++;
            $display("%0t: row exp %0d got %0d", $realtime, exp_ln.row, got.row);
        end
        if (exp_ln.column != got.column)
        begin
            errors++;
            $display("%0t: column exp %0d got %0d", $realtime, exp_ln.column, got.column);
        end
        if (exp_ln.line != got.line)
        begin
            errors++;
            $display("%0t: line exp %0d got %0d", $realtime, exp_ln.line, got.line);
        end
        if (exp_ln.pixels != got.pixels)
        begin
            errors++;
            $display("%0t: pixels exp %h got %h", $realtime, exp_ln.pixels, got.pixels);
        end
        if (exp_ln.wide != got.wide)
        begin
            errors++;
            $display("%0t: wide exp %0d got %0d", $realtime, exp_ln.wide, got.wide);
        end
        if (exp_ln.last != got.last)
        begin
            errors++;
            $display("%0t: last exp %0d got %0d", $realtime, exp_ln.last, got.last);
        end
    endfunction
endclass

module testbench;

    localparam int COLS_MAX  = 80;
    localparam int STALL_MAX = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    wire         s_tready;
    logic [31:0] s_tdata;
    wire         m_tvalid;
    logic        m_tready;
    wire  [39:0] m_tdata;
    wire         m_tuser;
    wire         m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tgcr_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    text_graphic_cell_renderer_core #(.MAX_COLUMNS(COLS_MAX)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [7:0]  char_mem [0:16383];
    logic        flag_mem [0:16383];
    logic [7:0]  font_mem [0:2047];
    logic [4:0]  blink_cnt;
    logic [10:0] walk_addr;
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;
    logic [2:0]  cur_colour;
    logic        frame_over;
    tgcr_pkg::cfg_t cfg;

    cell_line_board board;
    int  idle_count;
    int  render_count;
    bit  timed_out;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int row_width();
        int w;
        w = (cfg.chars_per_row == 0) ? 0 : int'(cfg.chars_per_row) - 1;
        return (w > COLS_MAX) ? COLS_MAX : w;
    endfunction

    function automatic logic [23:0] line_pixels(logic [7:0] bits, logic [2:0] lc,
                                                logic [2:0] rc, logic [2:0] bg);
        logic [23:0] v;
        v = '0;
        for (int i = 0; i < 8; i++)
            v = {v[20:0], bits[7-i] ? ((i < 4) ? lc : rc) : bg};
        return v;
    endfunction

    task automatic advance_cell();
        int rows;
        rows = cfg.display_mode[5] ? 25 : 24;
        cur_col++;
        if (int'(cur_col) >= row_width())
        begin
            cur_col = 0;
            cur_row = cur_row + 1;
            if (int'(cur_row) >= rows)
                frame_over = 1'b1;
        end
    endtask

    // Work out the eight lines of the next cell, if the walk yields one
    task automatic predict_render();
        logic [23:0] lines [8];
        logic [10:0] a;
        logic [1:0]  scr;
        logic        graph;
        logic [13:0] g;
        logic [7:0]  bits, b;
        logic [2:0]  lc, rc;
        logic [1:0]  bm;
        cell_line_t  ln;
        if (frame_over)
            return;
        if (cur_col == 0)
        begin
            cur_colour = char_mem[{3'b000, walk_addr}][2:0];
            walk_addr = walk_addr + 1;
        end
        if (row_width() == 0)
        begin
            advance_cell();
            return;
        end
        a = walk_addr;
        scr = (cfg.display_mode[7:6] > 2) ? 2'd2 : cfg.display_mode[7:6];
        graph = 1'b0;
        if (scr != 0)
            for (int k = 0; k < 8; k++)
            begin
                g = {3'b000, a} + 14'(k * 'h800);
                if (scr == 1)
                    g[11] = 1'b0;
                if (flag_mem[g])
                    graph = 1'b1;
            end
        for (int l = 0; l < 8; l++)
        begin
            bits = font_mem[{char_mem[{3'b000, a}], 3'(l)}];
            lc = cur_colour;
            rc = cur_colour;
            g = {3'b000, a} + 14'(l * 'h800);
            if (graph)
            begin
                if (scr == 1)
                begin
                    g[11] = 1'b0;
                    if (flag_mem[g])
                    begin
                        b = char_mem[g];
                        lc = b[6:4];
                        rc = b[2:0];
                        bits = {{4{|b[7:4]}}, {4{|b[3:0]}}};
                    end
                    else
                        bits = 8'h00;
                end
                else
                begin
                    bits = flag_mem[g] ? char_mem[g] : 8'h00;
                    lc = 3'd7;
                    rc = 3'd7;
                end
            end
            lines[l] = line_pixels(bits, lc, rc, cfg.display_mode[2:0]);
        end
        // cursor block
        bm = cfg.cursor_control[6:5];
        if (cfg.display_control[7:6] != 2'b11 && a == cfg.cursor_address)
            if (bm == tgcr_pkg::BLINK_STEADY || (bm == tgcr_pkg::BLINK_SLOW && blink_cnt[3])
                || (bm == tgcr_pkg::BLINK_FAST && blink_cnt[4]))
                for (int l = 0; l < 8; l++)
                    if (l >= cfg.cursor_control[2:0])
                        lines[l] = 24'hffffff;
        // blanking
        if (cfg.display_control[5:4] == 2'b11)
            for (int l = 0; l < 8; l++)
                lines[l] = '0;
        for (int l = 0; l < 8; l++)
        begin
            ln.row = cur_row;
            ln.column = cur_col;
            ln.line = 3'(l);
            ln.pixels = lines[l];
            ln.wide = ~cfg.display_mode[5];
            ln.last = (l == 7);
            board.note_line(ln);
        end
        render_count++;
        walk_addr = walk_addr + 1;
        advance_cell();
    endtask

    task automatic predict_item(logic [2:0] fn, logic [13:0] ad, logic [7:0] dt);
        case (fn)
            tgcr_pkg::FUNC_WR_CHAR: char_mem[ad] = dt;
            tgcr_pkg::FUNC_WR_FLAG: flag_mem[ad] = (dt != 0);
            tgcr_pkg::FUNC_WR_FONT: font_mem[ad[10:0]] = dt;
            tgcr_pkg::FUNC_TICK:    blink_cnt = blink_cnt + 1;
            tgcr_pkg::FUNC_START:
            begin
                walk_addr = cfg.start_address;
                cur_row = 0;
                cur_col = 0;
                frame_over = 1'b0;
            end
            tgcr_pkg::FUNC_RENDER:  predict_render();
            default: ;
        endcase
    endtask

    // drive one input beat after a random gap; tvalid stays up for a zero gap
    task automatic send_item(logic [2:0] fn, logic [13:0] ad, logic [7:0] dt);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, dt, ad, fn};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(fn, ad, dt);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= tgcr_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            tgcr_pkg::REG_DISPLAY_MODE:    cfg.display_mode = val[7:0];
            tgcr_pkg::REG_CHARS_PER_ROW:   cfg.chars_per_row = val[7:0];
            tgcr_pkg::REG_DISPLAY_CONTROL: cfg.display_control = val[7:0];
            tgcr_pkg::REG_CURSOR_CONTROL:  cfg.cursor_control = val[6:0];
            tgcr_pkg::REG_START_ADDRESS:   cfg.start_address = val[10:0];
            tgcr_pkg::REG_CURSOR_ADDRESS:  cfg.cursor_address = val[10:0];
            default: ;
        endcase
    endtask

    // block idle: all lines back plus a settling pause for result-less renders
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_lines.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // output side: random stalls, check each beat
    initial
    begin
        cell_line_t got;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = {m_tdata[4:0], m_tdata[11:5], m_tdata[14:12], m_tdata[38:15],
                   m_tuser, m_tlast};
            board.check_beat(got);
        end
    end

    // watchdog on accepted beats
    initial
    begin
        idle_count = 0;
        timed_out = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_MAX)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // one frame section: start then a run of renders with scattered other items
    task automatic frame_run(int n);
        logic [2:0] fn;
        send_item(tgcr_pkg::FUNC_START, 14'($urandom), 8'($urandom));
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0: fn = tgcr_pkg::FUNC_TICK;
                1: fn = tgcr_pkg::FUNC_WR_CHAR;
                2: fn = tgcr_pkg::FUNC_WR_FLAG;
                3: fn = tgcr_pkg::FUNC_WR_FONT;
                4: fn = 3'($urandom_range(6, 7));
                5: fn = tgcr_pkg::FUNC_START;
                default: fn = tgcr_pkg::FUNC_RENDER;
            endcase
            send_item(fn, 14'($urandom), 8'($urandom));
        end
    endtask

    // fill a small area with random content, biased to the walk window
    task automatic fill_stores(int n);
        logic [13:0] ad;
        for (int i = 0; i < n; i++)
        begin
            ad = {3'($urandom), 11'(cfg.start_address + $urandom_range(0, 40))};
            case ($urandom_range(0, 3))
                0: send_item(tgcr_pkg::FUNC_WR_CHAR, ad, 8'($urandom));
                1: send_item(tgcr_pkg::FUNC_WR_FLAG, ad,
                             ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00);
                default: send_item(tgcr_pkg::FUNC_WR_FONT, 14'($urandom), 8'($urandom));
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] modes [6];
        board = new();
        render_count = 0;
        for (int i = 0; i < 16384; i++)
        begin
            char_mem[i] = 0;
            flag_mem[i] = 0;
        end
        for (int i = 0; i < 2048; i++)
            font_mem[i] = 0;
        blink_cnt = 0;
        walk_addr = 0;
        cur_row = 0;
        cur_col = 0;
        cur_colour = 0;
        frame_over = 1'b1;
        cfg = '{display_mode: 8'd0, chars_per_row: 8'd81, display_control: 8'd0,
                cursor_control: 7'd0, start_address: 11'd0, cursor_address: 11'd0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: render before any start frame, then a steady cursor on cell 0
        send_item(tgcr_pkg::FUNC_RENDER, 14'h3fff, 8'hff);
        send_item(3'd6, 14'h0, 8'h0);
        send_item(3'd7, 14'h3fff, 8'hff);
        send_item(tgcr_pkg::FUNC_WR_CHAR, 14'h0000, 8'h05);
        send_item(tgcr_pkg::FUNC_WR_CHAR, 14'h0001, 8'hff);
        send_item(tgcr_pkg::FUNC_WR_FONT, 14'h3ff8, 8'hff);
        send_item(tgcr_pkg::FUNC_WR_FONT, 14'h07f9, 8'h81);
        send_item(tgcr_pkg::FUNC_WR_FLAG, 14'h3fff, 8'h00);
        send_item(tgcr_pkg::FUNC_WR_FLAG, 14'h2001, 8'h01);
        send_item(tgcr_pkg::FUNC_WR_CHAR, 14'h2001, 8'hf7);
        send_item(tgcr_pkg::FUNC_WR_CHAR, 14'h3fff, 8'h80);
        send_item(tgcr_pkg::FUNC_START, 14'h0, 8'h0);
        send_item(tgcr_pkg::FUNC_RENDER, 14'h0, 8'h0);
        send_item(tgcr_pkg::FUNC_RENDER, 14'h0, 8'h0);
        drain();
        write_reg(tgcr_pkg::REG_DISPLAY_MODE, 32'h000000ff);
        write_reg(tgcr_pkg::REG_CHARS_PER_ROW, 32'h00000003);
        write_reg(tgcr_pkg::REG_CURSOR_CONTROL, 32'h0000007f);
        write_reg(tgcr_pkg::REG_CURSOR_ADDRESS, 32'h000007ff);
        write_reg(tgcr_pkg::REG_START_ADDRESS, 32'h000007fe);
        write_reg(tgcr_pkg::REG_DISPLAY_CONTROL, 32'h000000ff);
        for (int i = 0; i < 16; i++)
            send_item(tgcr_pkg::FUNC_TICK, 14'h0, 8'h0);
        send_item(tgcr_pkg::FUNC_START, 14'h0, 8'h0);
        for (int i = 0; i < 4; i++)
            send_item(tgcr_pkg::FUNC_RENDER, 14'h0, 8'h0);
        drain();

        // random phases across register settings, extremes included
        modes = '{8'h00, 8'h27, 8'h45, 8'h62, 8'h83, 8'he6};
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(tgcr_pkg::REG_DISPLAY_MODE,
                      (ph < 6) ? modes[ph] : $urandom_range(0, 255));
            case (ph % 4)
                0: write_reg(tgcr_pkg::REG_CHARS_PER_ROW, $urandom_range(0, 1));
                1: write_reg(tgcr_pkg::REG_CHARS_PER_ROW, 255);
                default: write_reg(tgcr_pkg::REG_CHARS_PER_ROW, $urandom_range(2, 6));
            endcase
            write_reg(tgcr_pkg::REG_DISPLAY_CONTROL, (ph == 3) ? 32'h30 : (ph == 7) ? 32'hc0
                                                     : $urandom_range(0, 255));
            write_reg(tgcr_pkg::REG_CURSOR_CONTROL, $urandom_range(0, 127));
            write_reg(tgcr_pkg::REG_START_ADDRESS,
                      (ph == 5) ? 32'h7fc : $urandom_range(0, 2047));
            write_reg(tgcr_pkg::REG_CURSOR_ADDRESS, cfg.start_address + $urandom_range(0, 8));
            fill_stores(12);
            repeat ($urandom_range(0, 20))
                send_item(tgcr_pkg::FUNC_TICK, 14'($urandom), 8'($urandom));
            frame_run((ph % 4 == 1) ? 20 : 10);
            drain();
        end

        $display("Summary: %0d cells rendered, %0d line beats checked over 12 setting phases",
                 render_count, board.beats_seen);
        $display("All six modes, blanking, cursor blink and empty rows were exercised.");
        if (board.errors == 0 && board.pending_lines.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
